// File: src/i2cm_pkg.sv
// shared types and constants of the i2c register access master
package i2cm_pkg;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HALF_PERIOD = 2'd0,
        CFG_ACK_TIMEOUT = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_RS_PREP   = 4'd3,
        PH_TX_LOW    = 4'd4,
        PH_TX_HIGH   = 4'd5,
        PH_ACK_LOW   = 4'd6,
        PH_ACK_HIGH  = 4'd7,
        PH_ACK_POLL  = 4'd8,
        PH_RX_LOW    = 4'd9,
        PH_RX_HIGH   = 4'd10,
        PH_NACK_LOW  = 4'd11,
        PH_NACK_HIGH = 4'd12,
        PH_STOP_A    = 4'd13,
        PH_STOP_B    = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        STAGE_ADDR   = 2'd0,
        STAGE_OFFSET = 2'd1,
        STAGE_LAST   = 2'd2
    } stage_t;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] device_address;
        logic [7:0] register_offset;
        logic [7:0] write_data;
        logic       sda_sample;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } out_item_t;

    typedef struct packed {
        logic       start;
        logic       is_read;
        logic [6:0] device_address;
        logic [7:0] register_offset;
        logic [7:0] write_data;
        logic       sda_sample;
    } tick_item_t;

endpackage

// File: src/i2cm_front.sv
// front end: accepts tick items and classifies their command
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       push,
    output tick_item_t push_item,
    input  logic       queue_full
);

    always_comb
    begin
        push_item.start           = 1'b0;
        push_item.is_read         = 1'b0;
        push_item.device_address  = in_item.device_address;
        push_item.register_offset = in_item.register_offset;
        push_item.write_data      = in_item.write_data;
        push_item.sda_sample      = in_item.sda_sample;
        case (in_item.command)
            CMD_WRITE:
            begin
                push_item.start = 1'b1;
            end
            CMD_READ:
            begin
                push_item.start   = 1'b1;
                push_item.is_read = 1'b1;
            end
            default:
            begin
                push_item.start = 1'b0;
            end
        endcase
    end

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

endmodule

// File: src/i2cm_queue.sv
// small fifo of classified tick items between front and sequencer
module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tick_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output tick_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    tick_item_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");
`endif

endmodule

// File: src/i2cm_seq.sv
// back end: bus sequencer, configuration registers and output register
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   head_valid,
    input  tick_item_t             head_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item
);

    logic [7:0] half_period_reg;
    logic [7:0] ack_timeout_reg;

    phase_t     phase_reg,    phase_next;
    logic       is_read_reg,  is_read_next;
    logic [2:0] bit_reg,      bit_next;
    logic [7:0] shift_reg,    shift_next;
    logic [7:0] hc_reg,       hc_next;
    logic [7:0] poll_reg,     poll_next;
    logic [6:0] addr_reg,     addr_next;
    logic [7:0] offset_reg,   offset_next;
    logic [7:0] data_reg,     data_next;
    logic [7:0] rx_reg,       rx_next;
    logic       fail_reg,     fail_next;
    stage_t     stage_reg,    stage_next;
    logic       done_reg,     done_next;
    logic       out_valid_reg;
    out_item_t  out_item_reg;

    logic       start;
    phase_t     e_phase;
    logic [7:0] e_shift;
    logic       e_fail;
    logic [7:0] hp;
    logic       half_end;
    logic       ack_done;
    logic       scl_c;
    logic       sda_c;
    logic       drv_c;
    out_item_t  step_item;

    assign pop      = head_valid && (!out_valid_reg || !out_stall);
    assign start    = head_item.start && (phase_reg == PH_IDLE);
    assign e_phase  = start ? PH_START_A : phase_reg;
    assign e_shift  = start ? {head_item.device_address, 1'b0} : shift_reg;
    assign e_fail   = start ? 1'b0 : fail_reg;
    assign hp       = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;

    always_comb
    begin
        logic [7:0] e_hc;
        logic [7:0] e_poll;
        e_hc   = start ? 8'd0 : hc_reg;
        e_poll = start ? 8'd0 : poll_reg;

        phase_next   = phase_reg;
        is_read_next = is_read_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        hc_next      = hc_reg;
        poll_next    = poll_reg;
        addr_next    = addr_reg;
        offset_next  = offset_reg;
        data_next    = data_reg;
        rx_next      = rx_reg;
        fail_next    = fail_reg;
        stage_next   = stage_reg;
        done_next    = done_reg;
        half_end     = 1'b0;
        ack_done     = 1'b0;

        if (pop)
        begin
            done_next = 1'b0;
            if (start)
            begin
                addr_next    = head_item.device_address;
                offset_next  = head_item.register_offset;
                data_next    = head_item.write_data;
                is_read_next = head_item.is_read;
                stage_next   = STAGE_ADDR;
                bit_next     = 3'd0;
            end
            phase_next = e_phase;
            shift_next = e_shift;
            fail_next  = e_fail;
            hc_next    = e_hc;
            poll_next  = e_poll;

            if (e_phase == PH_IDLE)
            begin
                hc_next = 8'd0;
            end
            else if (e_phase == PH_ACK_POLL)
            begin
                if (!head_item.sda_sample)
                begin
                    ack_done = 1'b1;
                end
                else if (e_poll >= ack_timeout_reg)
                begin
                    fail_next = 1'b1;
                    ack_done  = 1'b1;
                end
                else
                begin
                    poll_next = e_poll + 8'd1;
                end
            end
            else
            begin
                if (e_phase == PH_RX_HIGH && e_hc == 8'd0)
                begin
                    shift_next = {e_shift[6:0], head_item.sda_sample};
                end
                half_end = ({1'b0, e_hc} + 9'd1) >= {1'b0, hp};
                if (!half_end)
                begin
                    hc_next = e_hc + 8'd1;
                end
            end

            if (ack_done)
            begin
                hc_next  = 8'd0;
                bit_next = 3'd0;
                case (stage_next)
                    STAGE_ADDR:
                    begin
                        shift_next = offset_next;
                        stage_next = STAGE_OFFSET;
                        phase_next = PH_TX_LOW;
                    end
                    STAGE_OFFSET:
                    begin
                        stage_next = STAGE_LAST;
                        if (is_read_next)
                        begin
                            shift_next = {addr_next, 1'b1};
                            phase_next = PH_RS_PREP;
                        end
                        else
                        begin
                            shift_next = data_next;
                            phase_next = PH_TX_LOW;
                        end
                    end
                    default:
                    begin
                        if (is_read_next)
                        begin
                            shift_next = 8'd0;
                            phase_next = PH_RX_LOW;
                        end
                        else
                        begin
                            phase_next = PH_STOP_A;
                        end
                    end
                endcase
            end

            if (half_end)
            begin
                hc_next = 8'd0;
                case (e_phase)
                    PH_START_A:   phase_next = PH_START_B;
                    PH_START_B:
                    begin
                        bit_next   = 3'd0;
                        phase_next = PH_TX_LOW;
                    end
                    PH_RS_PREP:   phase_next = PH_START_A;
                    PH_TX_LOW:    phase_next = PH_TX_HIGH;
                    PH_TX_HIGH:
                    begin
                        shift_next = {shift_next[6:0], 1'b0};
                        if (bit_next == 3'd7)
                        begin
                            bit_next   = 3'd0;
                            phase_next = PH_ACK_LOW;
                        end
                        else
                        begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = PH_TX_LOW;
                        end
                    end
                    PH_ACK_LOW:   phase_next = PH_ACK_HIGH;
                    PH_ACK_HIGH:
                    begin
                        poll_next  = 8'd0;
                        phase_next = PH_ACK_POLL;
                    end
                    PH_RX_LOW:    phase_next = PH_RX_HIGH;
                    PH_RX_HIGH:
                    begin
                        if (bit_next == 3'd7)
                        begin
                            rx_next    = shift_next;
                            bit_next   = 3'd0;
                            phase_next = PH_NACK_LOW;
                        end
                        else
                        begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = PH_RX_LOW;
                        end
                    end
                    PH_NACK_LOW:  phase_next = PH_NACK_HIGH;
                    PH_NACK_HIGH: phase_next = PH_STOP_A;
                    PH_STOP_A:    phase_next = PH_STOP_B;
                    PH_STOP_B:
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    default:      phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_comb
    begin
        scl_c = 1'b1;
        sda_c = 1'b1;
        drv_c = 1'b1;
        case (e_phase)
            PH_START_B:
            begin
                sda_c = 1'b0;
            end
            PH_RS_PREP, PH_NACK_LOW:
            begin
                scl_c = 1'b0;
            end
            PH_TX_LOW:
            begin
                scl_c = 1'b0;
                sda_c = e_shift[7];
            end
            PH_TX_HIGH:
            begin
                sda_c = e_shift[7];
            end
            PH_ACK_LOW, PH_RX_LOW:
            begin
                scl_c = 1'b0;
                drv_c = 1'b0;
            end
            PH_ACK_HIGH, PH_ACK_POLL, PH_RX_HIGH:
            begin
                drv_c = 1'b0;
            end
            PH_STOP_A:
            begin
                scl_c = 1'b0;
                sda_c = 1'b0;
            end
            PH_STOP_B:
            begin
                sda_c = 1'b0;
            end
            default:
            begin
                scl_c = 1'b1;
            end
        endcase
        step_item.scl_level        = scl_c;
        step_item.sda_level        = sda_c;
        step_item.sda_drive_enable = drv_c;
        step_item.busy_res         = (e_phase != PH_IDLE);
        step_item.done_res         = done_reg;
        step_item.read_data        = rx_reg;
        step_item.ack_missing      = e_fail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: half_period_reg <= cfg_data;
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            is_read_reg   <= 1'b0;
            bit_reg       <= 3'd0;
            shift_reg     <= 8'd0;
            hc_reg        <= 8'd0;
            poll_reg      <= 8'd0;
            addr_reg      <= 7'd0;
            offset_reg    <= 8'd0;
            data_reg      <= 8'd0;
            rx_reg        <= 8'd0;
            fail_reg      <= 1'b0;
            stage_reg     <= STAGE_ADDR;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            is_read_reg <= is_read_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            hc_reg      <= hc_next;
            poll_reg    <= poll_next;
            addr_reg    <= addr_next;
            offset_reg  <= offset_next;
            data_reg    <= data_next;
            rx_reg      <= rx_next;
            fail_reg    <= fail_next;
            stage_reg   <= stage_next;
            done_reg    <= done_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= step_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef NO_ASSERTIONS
    a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.busy_res |->
            out_item.scl_level && out_item.sda_level && out_item.sda_drive_enable)
        else $error("idle item does not show a free bus");
    a_done_free_bus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.done_res |->
            out_item.scl_level && out_item.sda_level && out_item.sda_drive_enable)
        else $error("done pulse without a free bus");
    a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.sda_drive_enable |-> out_item.sda_level)
        else $error("released sda not reported high");
    a_idle_counter: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> hc_reg == 8'd0)
        else $error("half counter running while idle");
`endif

endmodule

// File: src/i2c_master_register_access_top.sv
// top level of the i2c single byte register access master
// Each input item is one timing tick: a command (tick only, register write or
// register read) with address, offset, data and the sampled sda level. Each
// accepted item yields exactly one output item with the scl/sda levels, sda
// drive enable, busy, done, read data and ack status for that tick.
// Commands are taken only while idle; other commands and code 3 act as ticks.
// The configuration channel (cfg_valid/cfg_ready, always ready) writes the
// half period (index 0) and ack timeout (index 1); write only while idle.
// An accepted item passes the queue, then the result register, before it is valid.
// Throughput: one item per cycle while out_stall is low, with the two-entry
// queue between the front end and the sequencer.
// When out_stall is high the result register holds; the queue fills and then
// in_stall rises until the receiver takes results again.
// Reset: bus idle (scl 1, sda 1 driven), half period 5, ack timeout 250,
// queue and output register empty.
module i2c_master_register_access_top
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    logic       push;
    tick_item_t push_item;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    tick_item_t head_item;

    assign cfg_ready = 1'b1;

    i2cm_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    i2cm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

// File: tb/i2c_master_register_access_top_test.sv
// self-checking testbench of the i2c register access master with a tick-level bus model
module i2c_master_register_access_top_test
    import i2cm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT_RESULT = 140;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 60;

    typedef enum {
        ACK_NOW,
        ACK_SLOW,
        ACK_NONE
    } ack_plan_t;

    class bus_tick_scoreboard;
        logic [7:0] half_period;
        logic [7:0] ack_timeout;
        phase_t     bus_phase;
        logic       is_read;
        logic [2:0] bit_idx;
        logic [7:0] shift_q;
        logic [7:0] half_cnt;
        logic [7:0] poll_cnt;
        logic [6:0] addr_q;
        logic [7:0] offset_q;
        logic [7:0] data_q;
        logic [7:0] rx_byte;
        logic       ack_lost;
        stage_t     stage;
        logic       done_pend;
        out_item_t  pending_levels[$];
        int         failures;

        function new();
            half_period = HALF_PERIOD_RESET;
            ack_timeout = ACK_TIMEOUT_RESET;
            bus_phase = PH_IDLE;
            is_read = 1'b0;
            bit_idx = '0;
            shift_q = '0;
            half_cnt = '0;
            poll_cnt = '0;
            addr_q = '0;
            offset_q = '0;
            data_q = '0;
            rx_byte = '0;
            ack_lost = 1'b0;
            stage = STAGE_ADDR;
            done_pend = 1'b0;
            failures = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [7:0] val);
            case (idx)
                CFG_HALF_PERIOD: half_period = val;
                CFG_ACK_TIMEOUT: ack_timeout = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction

        function void after_ack();
            half_cnt = '0;
            bit_idx = '0;
            case (stage)
                STAGE_ADDR:
                begin
                    shift_q = offset_q;
                    stage = STAGE_OFFSET;
                    bus_phase = PH_TX_LOW;
                end
                STAGE_OFFSET:
                begin
                    stage = STAGE_LAST;
                    if (is_read)
                    begin
                        shift_q = {addr_q, 1'b1};
                        bus_phase = PH_RS_PREP;
                    end
                    else
                    begin
                        shift_q = data_q;
                        bus_phase = PH_TX_LOW;
                    end
                end
                default:
                begin
                    if (is_read)
                    begin
                        shift_q = '0;
                        bus_phase = PH_RX_LOW;
                    end
                    else
                        bus_phase = PH_STOP_A;
                end
            endcase
        endfunction

        function void note_tick(in_item_t it);
            out_item_t  levels;
            logic [7:0] hp;
            logic       scl;
            logic       sda;
            logic       drive;
            hp = (half_period == 8'd0) ? 8'd1 : half_period;
            if (bus_phase == PH_IDLE && (it.command == CMD_WRITE || it.command == CMD_READ))
            begin
                addr_q = it.device_address;
                offset_q = it.register_offset;
                data_q = it.write_data;
                is_read = (it.command == CMD_READ);
                ack_lost = 1'b0;
                stage = STAGE_ADDR;
                bit_idx = '0;
                half_cnt = '0;
                poll_cnt = '0;
                shift_q = {it.device_address, 1'b0};
                bus_phase = PH_START_A;
            end

            scl = 1'b1;
            sda = 1'b1;
            drive = 1'b1;
            case (bus_phase)
                PH_START_B: sda = 1'b0;
                PH_RS_PREP: scl = 1'b0;
                PH_TX_LOW:
                begin
                    scl = 1'b0;
                    sda = shift_q[7];
                end
                PH_TX_HIGH: sda = shift_q[7];
                PH_ACK_LOW, PH_RX_LOW:
                begin
                    scl = 1'b0;
                    drive = 1'b0;
                end
                PH_ACK_HIGH, PH_ACK_POLL, PH_RX_HIGH: drive = 1'b0;
                PH_NACK_LOW: scl = 1'b0;
                PH_STOP_A:
                begin
                    scl = 1'b0;
                    sda = 1'b0;
                end
                PH_STOP_B: sda = 1'b0;
                default: ;
            endcase

            levels.scl_level = scl;
            levels.sda_level = sda;
            levels.sda_drive_enable = drive;
            levels.busy_res = (bus_phase != PH_IDLE);
            levels.done_res = done_pend;
            levels.read_data = rx_byte;
            levels.ack_missing = ack_lost;
            pending_levels.push_back(levels);
            done_pend = 1'b0;

            if (bus_phase == PH_IDLE)
                half_cnt = '0;
            else if (bus_phase == PH_ACK_POLL)
            begin
                if (!it.sda_sample)
                    after_ack();
                else if (poll_cnt >= ack_timeout)
                begin
                    ack_lost = 1'b1;
                    after_ack();
                end
                else
                    poll_cnt++;
            end
            else
            begin
                if (bus_phase == PH_RX_HIGH && half_cnt == 8'd0)
                    shift_q = {shift_q[6:0], it.sda_sample};
                if ({1'b0, half_cnt} + 9'd1 >= {1'b0, hp})
                begin
                    half_cnt = '0;
                    case (bus_phase)
                        PH_START_A: bus_phase = PH_START_B;
                        PH_START_B:
                        begin
                            bit_idx = '0;
                            bus_phase = PH_TX_LOW;
                        end
                        PH_RS_PREP: bus_phase = PH_START_A;
                        PH_TX_LOW: bus_phase = PH_TX_HIGH;
                        PH_TX_HIGH:
                        begin
                            shift_q = {shift_q[6:0], 1'b0};
                            if (bit_idx == 3'd7)
                            begin
                                bit_idx = '0;
                                bus_phase = PH_ACK_LOW;
                            end
                            else
                            begin
                                bit_idx++;
                                bus_phase = PH_TX_LOW;
                            end
                        end
                        PH_ACK_LOW: bus_phase = PH_ACK_HIGH;
                        PH_ACK_HIGH:
                        begin
                            poll_cnt = '0;
                            bus_phase = PH_ACK_POLL;
                        end
                        PH_RX_LOW: bus_phase = PH_RX_HIGH;
                        PH_RX_HIGH:
                        begin
                            if (bit_idx == 3'd7)
                            begin
                                rx_byte = shift_q;
                                bit_idx = '0;
                                bus_phase = PH_NACK_LOW;
                            end
                            else
                            begin
                                bit_idx++;
                                bus_phase = PH_RX_LOW;
                            end
                        end
                        PH_NACK_LOW: bus_phase = PH_NACK_HIGH;
                        PH_NACK_HIGH: bus_phase = PH_STOP_A;
                        PH_STOP_A: bus_phase = PH_STOP_B;
                        PH_STOP_B:
                        begin
                            bus_phase = PH_IDLE;
                            done_pend = 1'b1;
                        end
                        default: bus_phase = PH_IDLE;
                    endcase
                end
                else
                    half_cnt++;
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_bus_levels(out_item_t got);
            out_item_t want;
            if (pending_levels.size() == 0)
            begin
                $error("result item %h with nothing expected", got);
                failures++;
                return;
            end
            want = pending_levels.pop_front();
            compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
            compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
            compare_field("sda_drive_enable", 8'(want.sda_drive_enable),
                          8'(got.sda_drive_enable));
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("ack_missing", 8'(want.ack_missing), 8'(got.ack_missing));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data = '0;

    bus_tick_scoreboard sb = new();
    ack_plan_t          ack_plan = ACK_NOW;
    int                 items_sent = 0;
    bit                 in_quiet = 1'b0;
    bit                 out_quiet = 1'b0;
    int                 out_wait = 0;
    int                 hold_left = 0;
    int                 results_seen = 0;
    int                 cycle_count = 0;

    i2c_master_register_access_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic in_item_t make_tick(logic [1:0] cmd);
        in_item_t it;
        it.command = cmd;
        it.device_address = 7'($urandom);
        it.register_offset = 8'($urandom);
        it.write_data = 8'($urandom);
        if (sb.bus_phase == PH_ACK_POLL)
        begin
            case (ack_plan)
                ACK_NOW: it.sda_sample = 1'b0;
                ACK_SLOW: it.sda_sample = ($urandom_range(0, 3) != 0);
                default: it.sda_sample = 1'b1;
            endcase
        end
        else
            it.sda_sample = 1'($urandom);
        return it;
    endfunction

    task automatic send_tick(in_item_t it);
        int gap;
        if ($urandom_range(0, 39) == 0)
            in_quiet = !in_quiet;
        gap = in_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        sb.note_tick(it);
        items_sent++;
    endtask

    // commands while busy must be ignored
    task automatic busy_tick();
        logic [1:0] cmd;
        cmd = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(1, 3)) : CMD_TICK;
        send_tick(make_tick(cmd));
    endtask

    task automatic run_transfer(cmd_t cmd, logic [6:0] addr, logic [7:0] offset,
                                logic [7:0] data, ack_plan_t plan);
        in_item_t it;
        ack_plan = plan;
        while (sb.bus_phase != PH_IDLE)
            busy_tick();
        it = make_tick(cmd);
        it.device_address = addr;
        it.register_offset = offset;
        it.write_data = data;
        send_tick(it);
        while (sb.bus_phase != PH_IDLE)
            busy_tick();
    endtask

    task automatic set_config(logic [7:0] half_period, logic [7:0] timeout);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HALF_PERIOD;
        cfg_data <= half_period;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(CFG_HALF_PERIOD, half_period);
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_data <= timeout;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(CFG_ACK_TIMEOUT, timeout);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_bus_levels(out_item);
                results_seen++;
                if ($urandom_range(0, 39) == 0)
                    out_quiet = !out_quiet;
                out_wait = out_quiet ? 0 : $urandom_range(0, 11);
                // long hold so the input side backs up
                if (results_seen == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (out_wait > 0)
            begin
                out_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int goal;
        ack_plan_t plan;
        in_item_t first;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values in use, then a faster bus in the middle of a half period
        send_tick(make_tick(CMD_TICK));
        send_tick(make_tick(CMD_UNUSED));
        ack_plan = ACK_NOW;
        first = make_tick(CMD_WRITE);
        first.device_address = 7'h7f;
        first.register_offset = 8'h00;
        first.write_data = 8'hff;
        send_tick(first);
        repeat (40) busy_tick();

        // zero timeout
        set_config(8'd1, 8'd0);
        ack_plan = ACK_NONE;
        while (sb.bus_phase != PH_IDLE)
            busy_tick();
        run_transfer(CMD_READ, 7'h7f, 8'h00, 8'hff, ACK_SLOW);

        // zero half period, longest timeout
        set_config(8'd0, 8'd255);
        run_transfer(CMD_READ, 7'h2a, 8'h55, 8'haa, ACK_NOW);
        run_transfer(CMD_WRITE, 7'h55, 8'haa, 8'h55, ACK_SLOW);

        repeat (2)
        begin
            set_config(8'($urandom_range(1, 2)), 8'($urandom_range(0, 7)));
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                repeat ($urandom_range(0, 2))
                    send_tick(make_tick($urandom_range(0, 1) ? CMD_TICK : CMD_UNUSED));
                case ($urandom_range(0, 5))
                    0: plan = ACK_NONE;
                    1, 2: plan = ACK_SLOW;
                    default: plan = ACK_NOW;
                endcase
                run_transfer($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 7'($urandom),
                             8'($urandom), 8'($urandom), plan);
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
